@@ design/srb_pkg.sv @@
// Package for the sequence reorder buffer: result codes, field widths and
// the command/status bundles shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package srb_pkg;

  // Default reorder window, in packets
  localparam int DEFAULT_WINDOW = 32;

  // Field widths
  localparam int NUMBER_W = 32;
  localparam int SIZE_W   = 16;
  localparam int HELD_W   = 21;
  localparam int TOTAL_W  = 22;
  localparam int STATUS_W = 2;

  // Packed stream widths (whole bytes)
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 72;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVERED = 2'd0,
    ST_STORED    = 2'd1,
    ST_STALE     = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input transfer
    logic classify;  // sort the captured packet and form its first result
    logic drain;     // deliver the held packet at the head slot
  } srb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;      // result in the output register ends this input
  } srb_stat_t;

endpackage

`default_nettype wire

@@ design/srb_ctrl.sv @@
// Controller state machine of the sequence reorder buffer.
// Depends on srb_pkg for the command and status bundles.
`default_nettype none

module srb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t  cmd
);
  import srb_pkg::*;

  typedef enum logic [3:0] {
    IDLE     = 4'b0001,
    CLASSIFY = 4'b0010,
    OUT_WAIT = 4'b0100,
    DRAIN    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one input: capture, classify, hand out results until last
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd          = '0;
    unique case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = CLASSIFY;
        end
      end
      CLASSIFY: begin
        cmd.classify = 1'b1;
        state_next   = OUT_WAIT;
      end
      OUT_WAIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (stat.last) begin
            // final result leaves: take the next packet in the same cycle
            s_tready = 1'b1;
            if (s_tvalid) begin
              cmd.load_in = 1'b1;
              state_next  = CLASSIFY;
            end else begin
              state_next = IDLE;
            end
          end else begin
            state_next = DRAIN;
          end
        end
      end
      DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = OUT_WAIT;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/srb_datapath.sv @@
// Datapath of the sequence reorder buffer: expected number, slot valid bits,
// slot size memory, byte total and the output register.
// Depends on srb_pkg.
`default_nettype none

module srb_datapath #(
  parameter int WINDOW = srb_pkg::DEFAULT_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  srb_pkg::srb_cmd_t               cmd,
  output srb_pkg::srb_stat_t              stat,
  input  logic [srb_pkg::NUMBER_W-1:0]    in_number,
  input  logic [srb_pkg::SIZE_W-1:0]      in_size,
  output srb_pkg::status_t                out_status,
  output logic [srb_pkg::NUMBER_W-1:0]    out_number,
  output logic [srb_pkg::SIZE_W-1:0]      out_size,
  output logic [srb_pkg::HELD_W-1:0]      out_held,
  output logic                            out_last
);
  import srb_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W:0]       WIN_EXT = (SLOT_W+1)'(WINDOW);
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [NUMBER_W-1:0]   WIN_NUM = NUMBER_W'(WINDOW);

  // Stored packet sizes, one entry per slot
  logic [SIZE_W-1:0] slot_size [WINDOW];
  logic [SIZE_W-1:0] rd_size;

  logic [NUMBER_W-1:0] number;
  logic [SIZE_W-1:0]   size;
  logic [NUMBER_W-1:0] expected_number;
  logic [SLOT_W-1:0]   head_slot;
  logic [WINDOW-1:0]   slot_valid;
  logic [TOTAL_W-1:0]  buffered_total;

  logic [NUMBER_W-1:0] seq_gap;
  logic [SLOT_W-1:0]   head_inc;
  logic [SLOT_W:0]     idx_sum;
  logic [SLOT_W-1:0]   idx;
  logic [TOTAL_W-1:0]  total_add;
  logic [TOTAL_W-1:0]  total_sub;
  logic                in_window;

  function automatic logic [HELD_W-1:0] saturate(input logic [TOTAL_W-1:0] t);
    logic [HELD_W-1:0] r;
    r = t[TOTAL_W-1] ? '1 : t[HELD_W-1:0];
    return r;
  endfunction

  // Distance from the expected number and target slot
  assign seq_gap   = number - expected_number;
  assign in_window = (seq_gap < WIN_NUM);
  assign head_inc  = (head_slot == LAST_SLOT) ? '0 : head_slot + 1'b1;
  assign idx_sum   = {1'b0, head_slot} + {1'b0, seq_gap[SLOT_W-1:0]};
  assign idx       = (idx_sum >= WIN_EXT) ? SLOT_W'(idx_sum - WIN_EXT)
                                          : idx_sum[SLOT_W-1:0];
  assign total_add = buffered_total + TOTAL_W'(size);
  assign total_sub = buffered_total - TOTAL_W'(rd_size);

  assign stat.last = out_last;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      number <= in_number;
      size   <= in_size;
    end
  end

  // Size memory: write on store, read the head slot every cycle
  always_ff @(posedge clk) begin
    if (cmd.classify && seq_gap != '0 && in_window && !slot_valid[idx]) begin
      slot_size[idx] <= size;
    end
    rd_size <= slot_size[head_slot];
  end

  // Control state: expected number, head slot, valid bits, byte total
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_number <= '0;
      head_slot       <= '0;
      slot_valid      <= '0;
      buffered_total  <= '0;
    end else if (cmd.classify) begin
      if (seq_gap == '0) begin
        expected_number <= expected_number + 1'b1;
        head_slot       <= head_inc;
      end else if (in_window && !slot_valid[idx]) begin
        slot_valid[idx] <= 1'b1;
        buffered_total  <= total_add;
      end
    end else if (cmd.drain) begin
      slot_valid[head_slot] <= 1'b0;
      buffered_total        <= total_sub;
      expected_number       <= expected_number + 1'b1;
      head_slot             <= head_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      out_number <= number;
      out_size   <= size;
      if (seq_gap == '0) begin
        out_status <= ST_DELIVERED;
        out_held   <= saturate(buffered_total);
        out_last   <= !slot_valid[head_inc];
      end else if (in_window && !slot_valid[idx]) begin
        out_status <= ST_STORED;
        out_held   <= saturate(total_add);
        out_last   <= 1'b1;
      end else begin
        // duplicate in the window or behind the expected number: stale
        out_status <= (in_window || seq_gap[NUMBER_W-1]) ? ST_STALE : ST_BEYOND;
        out_held   <= saturate(buffered_total);
        out_last   <= 1'b1;
      end
    end else if (cmd.drain) begin
      out_status <= ST_DELIVERED;
      out_number <= expected_number;
      out_size   <= rd_size;
      out_held   <= saturate(total_sub);
      out_last   <= !slot_valid[head_inc];
    end
  end

endmodule

`default_nettype wire

@@ design/sequence_reorder_buffer_unit.sv @@
// Sequence reorder buffer, top level: stream ports, controller and datapath.
// Depends on srb_pkg, srb_ctrl and srb_datapath.
`default_nettype none

// Packets arrive as (number, size). A packet with the expected number is
// delivered at once, followed by every held packet with the next numbers in
// order, one result per transfer; a packet up to WINDOW-1 ahead is held and
// its size added to held_bytes; stale, duplicate and too-far packets are
// dropped with their status. The result that ends an input carries tlast.
// An input that gives one result is captured and classified, then its result
// is held in the result register; each drained packet is read from the slot
// size memory and then placed in the result register. A new packet is taken in
// the cycle its final result is transferred. There is no clearing pass after
// reset: slot valid bits are cleared at once.

module sequence_reorder_buffer_unit #(
  parameter int WINDOW = srb_pkg::DEFAULT_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [31:0] packet_number, [47:32] packet_size
  input  logic [srb_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] out_number, [47:32] out_size, [68:48] held_bytes, [71:69] zero
  output logic [srb_pkg::M_DATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic [srb_pkg::STATUS_W-1:0]  m_tuser,
  output logic                          m_tlast
);
  import srb_pkg::*;

  srb_cmd_t            cmd;
  srb_stat_t           stat;
  status_t             out_status;
  logic [NUMBER_W-1:0] out_number;
  logic [SIZE_W-1:0]   out_size;
  logic [HELD_W-1:0]   out_held;

  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srb_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_number  (s_tdata[NUMBER_W-1:0]),
    .in_size    (s_tdata[NUMBER_W+SIZE_W-1:NUMBER_W]),
    .out_status (out_status),
    .out_number (out_number),
    .out_size   (out_size),
    .out_held   (out_held),
    .out_last   (m_tlast)
  );

  // Pack the result
  assign m_tdata = {(M_DATA_W-NUMBER_W-SIZE_W-HELD_W)'(0), out_held, out_size, out_number};
  assign m_tuser = out_status;

  // A non-final result blocks new input
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted while results of the previous packet remain");

  // Captured packet is classified before any result or new input
  a_classify_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("classify cycle skipped after input transfer");

  // Only deliveries can be followed by drained packets
  a_drop_store_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_DELIVERED |-> m_tlast)
    else $error("stored or dropped packet not marked last");

endmodule

`default_nettype wire
